/* rtl/tpc_pkg.sv */
package tpc_pkg;

  localparam int COORD_W = 32;
  localparam int T_BITS  = 30;
  localparam int PROD_W  = 64;
  localparam int S_W     = 66;   // n.v - d, exact
  localparam int DIFF_W  = 67;   // s_u - s_w
  localparam int DEN_W   = 67;
  localparam int REM_W   = 68;
  localparam int IDX_W   = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_NORMAL_X     = 2'd0,
    REG_NORMAL_Y     = 2'd1,
    REG_NORMAL_Z     = 2'd2,
    REG_PLANE_OFFSET = 2'd3
  } reg_idx_t;

  localparam logic [COORD_W-1:0] NORMAL_Z_RESET = 32'h4000_0000;
  localparam logic [T_BITS:0]    T_ONE          = {1'b1, {T_BITS{1'b0}}};

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  // rotated triangle: p is the lone vertex, nk the kept count
  typedef struct packed {
    vec_t       p;
    vec_t       q;
    vec_t       r;
    logic [1:0] nk;
  } tri_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [T_BITS-1:0] quo;
    logic              zero;
    logic              sat;
  } div_t;

  // one restoring division step
  function automatic div_t div_step(input div_t d);
    div_t             r;
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] dn;
    r  = d;
    r2 = {d.rem[REM_W-2:0], 1'b0};
    dn = REM_W'(d.den);
    if (r2 >= dn) begin
      r.rem = r2 - dn;
      r.quo = {d.quo[T_BITS-2:0], 1'b1};
    end else begin
      r.rem = r2;
      r.quo = {d.quo[T_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

/* rtl/triangle_plane_clipper_unit.sv */
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  ax ay az bx by_coord bz cx cy cz
// output    out        out_valid/out_stall  out_ax .. out_cz, last_triangle
// config    in         cfg_we               cfg_index, cfg_data
//
// One triangle is taken per cycle while in_stall is low; 39 register stages
// (2 distance, 3 setup, 30 divider steps, 3 interpolation, 1 output).
// A two-kept triangle leaves the output register as two transactions and
// freezes every stage, all on one enable, until the second is taken.
// Reset (rst, synchronous) clears all valid bits and loads the reset plane.
// in_stall is high exactly while the output register holds a triangle that is
// not being taken as its last transaction.
module triangle_plane_clipper_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  tpc_pkg::coord_t           ax,
  input  tpc_pkg::coord_t           ay,
  input  tpc_pkg::coord_t           az,
  input  tpc_pkg::coord_t           bx,
  input  tpc_pkg::coord_t           by_coord,
  input  tpc_pkg::coord_t           bz,
  input  tpc_pkg::coord_t           cx,
  input  tpc_pkg::coord_t           cy,
  input  tpc_pkg::coord_t           cz,
  output logic                      out_valid,
  input  logic                      out_stall,
  output tpc_pkg::coord_t           out_ax,
  output tpc_pkg::coord_t           out_ay,
  output tpc_pkg::coord_t           out_az,
  output tpc_pkg::coord_t           out_bx,
  output tpc_pkg::coord_t           out_by,
  output tpc_pkg::coord_t           out_bz,
  output tpc_pkg::coord_t           out_cx,
  output tpc_pkg::coord_t           out_cy,
  output tpc_pkg::coord_t           out_cz,
  output logic                      last_triangle,
  input  logic                      cfg_we,
  input  logic [tpc_pkg::IDX_W-1:0] cfg_index,
  input  logic [tpc_pkg::COORD_W-1:0] cfg_data
);
  import tpc_pkg::*;

  // plane registers
  coord_t normal_x, normal_y, normal_z, plane_offset;

  // pipeline enable: all stages advance together
  logic adv;

  vec_t  va, vb, vc;
  vec_t  da, db, dc;
  logic  dist_v;
  logic signed [S_W-1:0] sa, sb, sc;

  logic  div_v  [T_BITS+1];
  tri_t  div_tri[T_BITS+1];
  div_t  div_pq [T_BITS+1];
  div_t  div_pr [T_BITS+1];

  logic  lerp_v;
  tri_t  lerp_tri;
  vec_t  lerp_pq, lerp_pr;

  // output register: whole item, phase picks the triangle
  logic  ob_valid;
  logic  ph;
  tri_t  ob_tri;
  vec_t  ob_pq, ob_pr;
  logic  last_ph;
  vec_t  o_a, o_b, o_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_x     <= '0;
      normal_y     <= '0;
      normal_z     <= NORMAL_Z_RESET;
      plane_offset <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_NORMAL_X:     normal_x     <= cfg_data;
        REG_NORMAL_Y:     normal_y     <= cfg_data;
        REG_NORMAL_Z:     normal_z     <= cfg_data;
        REG_PLANE_OFFSET: plane_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  assign va = '{x: ax, y: ay, z: az};
  assign vb = '{x: bx, y: by_coord, z: bz};
  assign vc = '{x: cx, y: cy, z: cz};

  // signed distance of each vertex
  tpc_dist u_dist (
    .clk, .rst, .en(adv), .in_v(in_valid),
    .a(va), .b(vb), .c(vc),
    .nx(normal_x), .ny(normal_y), .nz(normal_z), .d(plane_offset),
    .out_v(dist_v), .oa(da), .ob(db), .oc(dc),
    .sa, .sb, .sc
  );

  // classify, rotate, seed both edge divisions
  tpc_setup u_setup (
    .clk, .rst, .en(adv), .in_v(dist_v),
    .a(da), .b(db), .c(dc), .sa, .sb, .sc,
    .out_v(div_v[0]), .tri_o(div_tri[0]), .pq_o(div_pq[0]), .pr_o(div_pr[0])
  );

  // one quotient bit per stage for each crossing edge
  for (genvar g = 0; g < T_BITS; g++) begin : g_div
    tpc_div_step u_step (
      .clk, .rst, .en(adv), .in_v(div_v[g]),
      .tri_i(div_tri[g]), .pq_i(div_pq[g]), .pr_i(div_pr[g]),
      .out_v(div_v[g+1]), .tri_o(div_tri[g+1]),
      .pq_o(div_pq[g+1]), .pr_o(div_pr[g+1])
    );
  end

  // crossing points
  tpc_lerp u_lerp (
    .clk, .rst, .en(adv), .in_v(div_v[T_BITS]),
    .tri_i(div_tri[T_BITS]), .pq_i(div_pq[T_BITS]), .pr_i(div_pr[T_BITS]),
    .out_v(lerp_v), .tri_o(lerp_tri), .pq_pt(lerp_pq), .pr_pt(lerp_pr)
  );

  // only a two-kept item has a second transaction
  assign last_ph  = (ob_tri.nk != 2'd2) || ph;
  assign adv      = !ob_valid || (!out_stall && last_ph);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid <= 1'b0;
      ph       <= 1'b0;
    end else if (adv) begin
      // fully culled triangles are dropped here
      ob_valid <= lerp_v && (lerp_tri.nk != 2'd0);
      ph       <= 1'b0;
    end else if (!out_stall) begin
      ph <= 1'b1;
    end
    if (adv) begin
      ob_tri <= lerp_tri;
      ob_pq  <= lerp_pq;
      ob_pr  <= lerp_pr;
    end
  end

  always_comb begin
    case (ob_tri.nk)
      2'd1: begin
        o_a = ob_tri.p; o_b = ob_pq; o_c = ob_pr;
      end
      2'd2: begin
        if (ph) begin
          o_a = ob_tri.r; o_b = ob_pr; o_c = ob_pq;
        end else begin
          o_a = ob_pq; o_b = ob_tri.q; o_c = ob_tri.r;
        end
      end
      default: begin
        o_a = ob_tri.p; o_b = ob_tri.q; o_c = ob_tri.r;
      end
    endcase
  end

  assign out_valid     = ob_valid;
  assign out_ax        = o_a.x;
  assign out_ay        = o_a.y;
  assign out_az        = o_a.z;
  assign out_bx        = o_b.x;
  assign out_by        = o_b.y;
  assign out_bz        = o_b.z;
  assign out_cx        = o_c.x;
  assign out_cy        = o_c.y;
  assign out_cz        = o_c.z;
  assign last_triangle = last_ph;

  // a first-of-two transaction is always followed by its partner
  a_pair : assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_triangle && !out_stall |=> out_valid && last_triangle)
    else $error("second triangle of a pair missing");

  // the pipe only freezes behind a held result
  a_hold : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  // culled triangles never reach the output
  a_cull : assert property (@(posedge clk) disable iff (rst)
    ob_valid |-> ob_tri.nk != 2'd0)
    else $error("culled triangle in output register");

endmodule

/* rtl/tpc_dist.sv */
module tpc_dist (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_v,
  input  tpc_pkg::vec_t               a,
  input  tpc_pkg::vec_t               b,
  input  tpc_pkg::vec_t               c,
  input  tpc_pkg::coord_t             nx,
  input  tpc_pkg::coord_t             ny,
  input  tpc_pkg::coord_t             nz,
  input  tpc_pkg::coord_t             d,
  output logic                        out_v,
  output tpc_pkg::vec_t               oa,
  output tpc_pkg::vec_t               ob,
  output tpc_pkg::vec_t               oc,
  output logic signed [tpc_pkg::S_W-1:0] sa,
  output logic signed [tpc_pkg::S_W-1:0] sb,
  output logic signed [tpc_pkg::S_W-1:0] sc
);
  import tpc_pkg::*;

  vec_t               vin [3];
  vec_t               va  [3];
  logic               v1;
  logic signed [PROD_W-1:0] pr [3][3];
  logic signed [S_W-1:0]    dterm;

  assign vin[0] = a;
  assign vin[1] = b;
  assign vin[2] = c;
  assign dterm  = S_W'(d) <<< T_BITS;

  // stage 1: nine products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_v;
    end
    if (en) begin
      for (int v = 0; v < 3; v++) begin
        va[v]    <= vin[v];
        pr[v][0] <= PROD_W'(nx) * PROD_W'($signed(vin[v].x));
        pr[v][1] <= PROD_W'(ny) * PROD_W'($signed(vin[v].y));
        pr[v][2] <= PROD_W'(nz) * PROD_W'($signed(vin[v].z));
      end
    end
  end

  // stage 2: signed distances
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= v1;
    end
    if (en) begin
      oa <= va[0];
      ob <= va[1];
      oc <= va[2];
      sa <= S_W'(pr[0][0]) + S_W'(pr[0][1]) + S_W'(pr[0][2]) - dterm;
      sb <= S_W'(pr[1][0]) + S_W'(pr[1][1]) + S_W'(pr[1][2]) - dterm;
      sc <= S_W'(pr[2][0]) + S_W'(pr[2][1]) + S_W'(pr[2][2]) - dterm;
    end
  end

endmodule

/* rtl/tpc_setup.sv */
module tpc_setup (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_v,
  input  tpc_pkg::vec_t                  a,
  input  tpc_pkg::vec_t                  b,
  input  tpc_pkg::vec_t                  c,
  input  logic signed [tpc_pkg::S_W-1:0] sa,
  input  logic signed [tpc_pkg::S_W-1:0] sb,
  input  logic signed [tpc_pkg::S_W-1:0] sc,
  output logic                           out_v,
  output tpc_pkg::tri_t                  tri_o,
  output tpc_pkg::div_t                  pq_o,
  output tpc_pkg::div_t                  pr_o
);
  import tpc_pkg::*;

  logic               k0, k1, k2;
  logic [1:0]         nk;
  logic [1:0]         lone;
  tri_t               rot;
  logic signed [S_W-1:0] sp_n, sq_n, sr_n;

  logic               cv, dv;
  tri_t               ctri, dtri;
  logic signed [S_W-1:0]    sp;
  logic signed [DIFF_W-1:0] dq, dr;
  logic [DEN_W-1:0]   num, den_q, den_r;

  assign k0 = ~sa[S_W-1];
  assign k1 = ~sb[S_W-1];
  assign k2 = ~sc[S_W-1];
  assign nk = 2'(k0) + 2'(k1) + 2'(k2);

  always_comb begin
    if (nk == 2'd1) begin
      lone = k1 ? 2'd1 : (k2 ? 2'd2 : 2'd0);
    end else begin
      lone = !k1 ? 2'd1 : (!k2 ? 2'd2 : 2'd0);
    end
    rot.nk = nk;
    case (lone)
      2'd1: begin
        rot.p = b; rot.q = c; rot.r = a;
        sp_n = sb; sq_n = sc; sr_n = sa;
      end
      2'd2: begin
        rot.p = c; rot.q = a; rot.r = b;
        sp_n = sc; sq_n = sa; sr_n = sb;
      end
      default: begin
        rot.p = a; rot.q = b; rot.r = c;
        sp_n = sa; sq_n = sb; sr_n = sc;
      end
    endcase
  end

  // stage C: rotate, edge differences
  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= 1'b0;
    end else if (en) begin
      cv <= in_v;
    end
    if (en) begin
      ctri <= rot;
      sp   <= sp_n;
      dq   <= DIFF_W'(sp_n) - DIFF_W'(sq_n);
      dr   <= DIFF_W'(sp_n) - DIFF_W'(sr_n);
    end
  end

  // stage D: magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= 1'b0;
    end else if (en) begin
      dv <= cv;
    end
    if (en) begin
      dtri  <= ctri;
      num   <= sp[S_W-1] ? DEN_W'(-sp) : DEN_W'(sp);
      den_q <= dq[DIFF_W-1] ? DEN_W'(-dq) : DEN_W'(dq);
      den_r <= dr[DIFF_W-1] ? DEN_W'(-dr) : DEN_W'(dr);
    end
  end

  // stage E: special cases, divider seed
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= dv;
    end
    if (en) begin
      tri_o      <= dtri;
      pq_o.rem   <= REM_W'(num);
      pq_o.den   <= den_q;
      pq_o.quo   <= '0;
      pq_o.zero  <= (den_q == '0);
      pq_o.sat   <= (num >= den_q);
      pr_o.rem   <= REM_W'(num);
      pr_o.den   <= den_r;
      pr_o.quo   <= '0;
      pr_o.zero  <= (den_r == '0);
      pr_o.sat   <= (num >= den_r);
    end
  end

endmodule

/* rtl/tpc_div_step.sv */
module tpc_div_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_v,
  input  tpc_pkg::tri_t tri_i,
  input  tpc_pkg::div_t pq_i,
  input  tpc_pkg::div_t pr_i,
  output logic          out_v,
  output tpc_pkg::tri_t tri_o,
  output tpc_pkg::div_t pq_o,
  output tpc_pkg::div_t pr_o
);
  import tpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
    if (en) begin
      tri_o <= tri_i;
      pq_o  <= div_step(pq_i);
      pr_o  <= div_step(pr_i);
    end
  end

endmodule

/* rtl/tpc_lerp.sv */
module tpc_lerp (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_v,
  input  tpc_pkg::tri_t tri_i,
  input  tpc_pkg::div_t pq_i,
  input  tpc_pkg::div_t pr_i,
  output logic          out_v,
  output tpc_pkg::tri_t tri_o,
  output tpc_pkg::vec_t pq_pt,
  output tpc_pkg::vec_t pr_pt
);
  import tpc_pkg::*;

  localparam int DW = COORD_W + 1;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(64'sd1 <<< (T_BITS - 1));

  logic [T_BITS:0]   t_q_n, t_r_n;
  logic              v1, v2;
  tri_t              tri_s1, tri_s2;
  logic [T_BITS:0]   t_q, t_r;
  logic signed [DW-1:0]     dif [2][3];
  logic signed [PROD_W-1:0] prd [2][3];
  logic signed [PROD_W-1:0] dl  [2][3];

  assign t_q_n = pq_i.zero ? '0 : (pq_i.sat ? T_ONE : {1'b0, pq_i.quo});
  assign t_r_n = pr_i.zero ? '0 : (pr_i.sat ? T_ONE : {1'b0, pr_i.quo});

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      for (int i = 0; i < 3; i++) begin
        dl[e][i] = (prd[e][i] + HALF) >>> T_BITS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v1    <= in_v;
      v2    <= v1;
      out_v <= v2;
    end
    if (en) begin
      // edge deltas and t
      tri_s1    <= tri_i;
      t_q       <= t_q_n;
      t_r       <= t_r_n;
      dif[0][0] <= DW'($signed(tri_i.q.x)) - DW'($signed(tri_i.p.x));
      dif[0][1] <= DW'($signed(tri_i.q.y)) - DW'($signed(tri_i.p.y));
      dif[0][2] <= DW'($signed(tri_i.q.z)) - DW'($signed(tri_i.p.z));
      dif[1][0] <= DW'($signed(tri_i.r.x)) - DW'($signed(tri_i.p.x));
      dif[1][1] <= DW'($signed(tri_i.r.y)) - DW'($signed(tri_i.p.y));
      dif[1][2] <= DW'($signed(tri_i.r.z)) - DW'($signed(tri_i.p.z));
      // products
      tri_s2 <= tri_s1;
      for (int i = 0; i < 3; i++) begin
        prd[0][i] <= PROD_W'(dif[0][i]) * PROD_W'($signed({1'b0, t_q}));
        prd[1][i] <= PROD_W'(dif[1][i]) * PROD_W'($signed({1'b0, t_r}));
      end
      // round half up, add to the lone vertex
      tri_o   <= tri_s2;
      pq_pt.x <= tri_s2.p.x + coord_t'(dl[0][0][COORD_W-1:0]);
      pq_pt.y <= tri_s2.p.y + coord_t'(dl[0][1][COORD_W-1:0]);
      pq_pt.z <= tri_s2.p.z + coord_t'(dl[0][2][COORD_W-1:0]);
      pr_pt.x <= tri_s2.p.x + coord_t'(dl[1][0][COORD_W-1:0]);
      pr_pt.y <= tri_s2.p.y + coord_t'(dl[1][1][COORD_W-1:0]);
      pr_pt.z <= tri_s2.p.z + coord_t'(dl[1][2][COORD_W-1:0]);
    end
  end

endmodule
